// ----- rtl/gsp_pkg.sv -----
package gsp_pkg;

  // fixed word format of all data fields (signed Q16.16)
  localparam int DATA_WIDTH = 32;
  localparam int TABLE_ENTRIES_DEF = 16;
  // product width of the shared 33 x 33 multiplier
  localparam int PROD_W = 66;
  // restoring divider: |diff| (33 bits) shifted left by 16
  localparam int DIV_W = 49;
  localparam int DIV_CNT_W = 6;
  // 1.4 in Q16.16
  localparam logic signed [32:0] BOOST_Q16 = 33'sd91750;

  localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // input commands
  localparam logic [1:0] CMD_SAMPLE    = 2'd0;
  localparam logic [1:0] CMD_WR_ENTRY  = 2'd1;
  localparam logic [1:0] CMD_WR_DEFAULT = 2'd2;
  localparam logic [1:0] CMD_WR_COMMON = 2'd3;

  // configuration register indexes
  localparam logic [3:0] CFG_MODE     = 4'd0;
  localparam logic [3:0] CFG_DT       = 4'd1;
  localparam logic [3:0] CFG_OUT_MAX  = 4'd2;
  localparam logic [3:0] CFG_OUT_MIN  = 4'd3;
  localparam logic [3:0] CFG_I_MAX    = 4'd4;
  localparam logic [3:0] CFG_ENTRIES  = 4'd5;
  localparam logic [3:0] CFG_USE_MAG  = 4'd6;
  localparam logic [3:0] CFG_EXT_SCHED = 4'd7;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_SEL_FIXED,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_MUL_P,
    OP_MUL_I,
    OP_SAT_I,
    OP_MUL_DT,
    OP_SAT_DT,
    OP_MUL_B,
    OP_SAT_B,
    OP_INTEG,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_MUL_D,
    OP_SAT_D,
    OP_SUM,
    OP_PUB
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_write;
    logic mode;
    logic scan_done;
    logic match;
    logic boost;
    logic div_last;
  } dp_stat_t;

  // Q16.16 product: floor shift by 16, then saturate to the data range
  function automatic logic signed [DATA_WIDTH-1:0] sat_q16(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] sh;
    logic signed [PROD_W-1:0] hi_l;
    logic signed [PROD_W-1:0] lo_l;
    begin
      sh = x >>> 16;
      hi_l = {{(PROD_W-DATA_WIDTH){1'b0}}, SAT_MAX};
      lo_l = {{(PROD_W-DATA_WIDTH){1'b1}}, SAT_MIN};
      if (sh > hi_l) sat_q16 = SAT_MAX;
      else if (sh < lo_l) sat_q16 = SAT_MIN;
      else sat_q16 = sh[DATA_WIDTH-1:0];
    end
  endfunction

endpackage

// ----- rtl/gsp_ctrl.sv -----
module gsp_ctrl
  import gsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [18:0] {
    S_IDLE     = 19'h00001,
    S_DISPATCH = 19'h00002,
    S_SCAN_RD  = 19'h00004,
    S_SCAN_CMP = 19'h00008,
    S_MP       = 19'h00010,
    S_MI       = 19'h00020,
    S_SAT_I    = 19'h00040,
    S_MDT      = 19'h00080,
    S_SAT_DT   = 19'h00100,
    S_MB       = 19'h00200,
    S_SAT_B    = 19'h00400,
    S_INTEG    = 19'h00800,
    S_DIV_INIT = 19'h01000,
    S_DIV      = 19'h02000,
    S_DIV_END  = 19'h04000,
    S_MD       = 19'h08000,
    S_SAT_D    = 19'h10000,
    S_SUM      = 19'h20000,
    S_DONE     = 19'h40000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   pub_ok;

  assign in_ready = (state == S_IDLE);
  assign pub_ok = !out_valid || out_ready;

  // next state and datapath operation
  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.is_write) begin
          state_next = S_DONE;
        end else if (stat.mode) begin
          cmd.op = OP_SCAN_INIT;
          state_next = S_SCAN_RD;
        end else begin
          cmd.op = OP_SEL_FIXED;
          state_next = S_MP;
        end
      end
      S_SCAN_RD: begin
        if (stat.scan_done) begin
          state_next = S_MP;
        end else begin
          cmd.op = OP_SCAN_RD;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        cmd.op = OP_SCAN_CMP;
        state_next = stat.match ? S_MP : S_SCAN_RD;
      end
      S_MP: begin
        cmd.op = OP_MUL_P;
        state_next = S_MI;
      end
      S_MI: begin
        cmd.op = OP_MUL_I;
        state_next = S_SAT_I;
      end
      S_SAT_I: begin
        cmd.op = OP_SAT_I;
        state_next = S_MDT;
      end
      S_MDT: begin
        cmd.op = OP_MUL_DT;
        state_next = S_SAT_DT;
      end
      S_SAT_DT: begin
        cmd.op = OP_SAT_DT;
        state_next = stat.boost ? S_MB : S_INTEG;
      end
      S_MB: begin
        cmd.op = OP_MUL_B;
        state_next = S_SAT_B;
      end
      S_SAT_B: begin
        cmd.op = OP_SAT_B;
        state_next = S_INTEG;
      end
      S_INTEG: begin
        cmd.op = OP_INTEG;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op = OP_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_last) state_next = S_DIV_END;
      end
      S_DIV_END: begin
        cmd.op = OP_DIV_END;
        state_next = S_MD;
      end
      S_MD: begin
        cmd.op = OP_MUL_D;
        state_next = S_SAT_D;
      end
      S_SAT_D: begin
        cmd.op = OP_SAT_D;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op = OP_SUM;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (pub_ok) begin
          cmd.op = OP_PUB;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // result word valid flag
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (state == S_DONE && pub_ok) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/gsp_dp.sv -----
module gsp_dp
  import gsp_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_fire,
  input  logic [1:0]                   in_cmd,
  input  logic [3:0]                   in_slot,
  input  logic signed [DATA_WIDTH-1:0] in_error,
  input  logic signed [DATA_WIDTH-1:0] in_nudge,
  input  logic signed [DATA_WIDTH-1:0] in_det,
  input  logic signed [DATA_WIDTH-1:0] in_lo,
  input  logic signed [DATA_WIDTH-1:0] in_hi,
  input  logic signed [DATA_WIDTH-1:0] in_gp,
  input  logic signed [DATA_WIDTH-1:0] in_gi,
  input  logic signed [DATA_WIDTH-1:0] in_gd,
  input  logic                         cfg_we,
  input  logic [3:0]                   cfg_index,
  input  logic [31:0]                  cfg_data,
  input  dp_cmd_t                      cmd,
  output dp_stat_t                     stat,
  output logic signed [DATA_WIDTH-1:0] res_drive,
  output logic signed [DATA_WIDTH-1:0] res_integ,
  output logic signed [DATA_WIDTH-1:0] res_deriv,
  output logic                         res_hit,
  output logic [3:0]                   res_idx
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int EW = 5 * DATA_WIDTH;

  // configuration registers
  logic        mode;
  logic [30:0] dt;
  logic signed [DATA_WIDTH-1:0] out_max, out_min;
  logic [30:0] i_max;
  logic [4:0]  entry_count;
  logic        use_mag, ext_sched;

  // loop state
  logic signed [DATA_WIDTH-1:0] prev_err, integ, last_drive;
  logic signed [DATA_WIDTH-1:0] def_p, def_i, def_d, com_p, com_i, com_d;

  // latched input word
  logic [1:0] cmd_r;
  logic [3:0] slot_r;
  logic signed [DATA_WIDTH-1:0] e_r, nudge_r, det_r, lo_r, hi_r, gp_r, gi_r, gd_r;

  // schedule table
  logic [EW-1:0] mem [TABLE_ENTRIES];
  logic [EW-1:0] rd;
  logic [CW-1:0] scan_idx, n_cnt;
  logic signed [DATA_WIDTH:0] s_r, s_raw, rd_lo, rd_hi;

  // working registers
  logic signed [DATA_WIDTH-1:0] kp, ki, kd, p, t, d, deriv, y_r;
  logic       hit;
  logic [3:0] hit_idx;
  logic signed [32:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  // divider
  logic [DIV_W-1:0] q;
  logic [30:0] rem;
  logic [31:0] rem_sh;
  logic        div_ge;
  logic        dsign, dzero;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic signed [DATA_WIDTH:0] diff;
  logic [DATA_WIDTH:0] diff_mag;

  logic signed [DATA_WIDTH:0] isum, ilim;
  logic signed [DATA_WIDTH+1:0] ysum, ysat;
  logic signed [DATA_WIDTH-1:0] deriv_new;

  // searched entries, limited to the table depth
  assign n_cnt = (int'(entry_count) > TABLE_ENTRIES) ? CW'(TABLE_ENTRIES) : CW'(entry_count);

  assign s_raw = ext_sched ? {det_r[DATA_WIDTH-1], det_r} : {e_r[DATA_WIDTH-1], e_r};
  assign rd_lo = {rd[DATA_WIDTH-1], rd[DATA_WIDTH-1:0]};
  assign rd_hi = {rd[2*DATA_WIDTH-1], rd[2*DATA_WIDTH-1:DATA_WIDTH]};

  assign stat.is_write = (cmd_r != CMD_SAMPLE);
  assign stat.mode = mode;
  assign stat.scan_done = (scan_idx >= n_cnt);
  assign stat.match = (s_r >= rd_lo) && (s_r < rd_hi);
  assign stat.boost = (integ > 0 && e_r < 0) || (e_r > 0 && integ < 0);
  assign stat.div_last = (div_cnt == DIV_CNT_W'(DIV_W - 1));

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_P: begin
        mul_a = 33'(kp);
        mul_b = 33'(e_r);
      end
      OP_MUL_I: begin
        mul_a = 33'(ki);
        mul_b = 33'(e_r);
      end
      OP_MUL_DT: begin
        mul_a = 33'(t);
        mul_b = {2'b00, dt};
      end
      OP_MUL_B: begin
        mul_a = 33'(t);
        mul_b = BOOST_Q16;
      end
      OP_MUL_D: begin
        mul_a = 33'(kd);
        mul_b = 33'(deriv);
      end
      default: ;
    endcase
  end

  // integral update with magnitude clamp
  assign ilim = {2'b00, i_max};
  assign isum = {integ[DATA_WIDTH-1], integ} + {t[DATA_WIDTH-1], t};

  // divider step and error change
  assign rem_sh = {rem, q[DIV_W-1]};
  assign div_ge = (rem_sh >= {1'b0, dt});
  assign diff = {e_r[DATA_WIDTH-1], e_r} - {prev_err[DATA_WIDTH-1], prev_err};
  assign diff_mag = diff[DATA_WIDTH] ? unsigned'(-diff) : unsigned'(diff);

  // quotient to signed derivative with saturation
  always_comb begin
    if (dzero) deriv_new = '0;
    else if (!dsign) deriv_new = (q > DIV_W'(SAT_MAX)) ? SAT_MAX : q[DATA_WIDTH-1:0];
    else deriv_new = (q > DIV_W'(unsigned'(SAT_MAX)) + DIV_W'(1)) ? SAT_MIN :
                     -q[DATA_WIDTH-1:0];
  end

  // drive sum and clamp
  assign ysum = 34'(p) + 34'(integ) - 34'(d) + 34'(nudge_r);
  always_comb begin
    if (ysum > 34'(out_max)) ysat = 34'(out_max);
    else if (ysum < 34'(out_min)) ysat = 34'(out_min);
    else ysat = ysum;
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_cmd;
      slot_r <= in_slot;
      e_r <= in_error;
      nudge_r <= in_nudge;
      det_r <= in_det;
      lo_r <= in_lo;
      hi_r <= in_hi;
      gp_r <= in_gp;
      gi_r <= in_gi;
      gd_r <= in_gd;
    end
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUB && cmd_r == CMD_WR_ENTRY && int'(slot_r) < TABLE_ENTRIES) begin
      mem[IW'(slot_r)] <= {gd_r, gi_r, gp_r, hi_r, lo_r};
    end
    if (cmd.op == OP_SCAN_RD) rd <= mem[IW'(scan_idx)];
  end

  // configuration and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      dt <= 31'd65536;
      out_max <= SAT_MAX;
      out_min <= SAT_MIN;
      i_max <= '1;
      entry_count <= '0;
      use_mag <= 1'b0;
      ext_sched <= 1'b0;
      prev_err <= '0;
      integ <= '0;
      last_drive <= '0;
      def_p <= '0;
      def_i <= '0;
      def_d <= '0;
      com_p <= '0;
      com_i <= '0;
      com_d <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODE: begin
            mode <= cfg_data[0];
            prev_err <= '0;
            integ <= '0;
            last_drive <= '0;
          end
          CFG_DT:        dt <= cfg_data[30:0];
          CFG_OUT_MAX:   out_max <= cfg_data;
          CFG_OUT_MIN:   out_min <= cfg_data;
          CFG_I_MAX:     i_max <= cfg_data[30:0];
          CFG_ENTRIES:   entry_count <= cfg_data[4:0];
          CFG_USE_MAG:   use_mag <= cfg_data[0];
          CFG_EXT_SCHED: ext_sched <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.op == OP_INTEG) begin
        if (isum > ilim) integ <= ilim[DATA_WIDTH-1:0];
        else if (isum < -ilim) integ <= DATA_WIDTH'(-ilim);
        else integ <= isum[DATA_WIDTH-1:0];
      end
      if (cmd.op == OP_PUB) begin
        if (cmd_r == CMD_SAMPLE) begin
          prev_err <= e_r;
          last_drive <= y_r;
        end else if (cmd_r == CMD_WR_DEFAULT) begin
          def_p <= gp_r;
          def_i <= gi_r;
          def_d <= gd_r;
        end else if (cmd_r == CMD_WR_COMMON) begin
          com_p <= gp_r;
          com_i <= gi_r;
          com_d <= gd_r;
        end
      end
    end
  end

  // gain select, products, divider and result word
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      OP_SEL_FIXED: begin
        kp <= com_p;
        ki <= com_i;
        kd <= com_d;
        hit <= 1'b0;
        hit_idx <= '0;
      end
      OP_SCAN_INIT: begin
        kp <= def_p;
        ki <= def_i;
        kd <= def_d;
        hit <= 1'b0;
        hit_idx <= '0;
        scan_idx <= '0;
        s_r <= (use_mag && s_raw < 0) ? -s_raw : s_raw;
      end
      OP_SCAN_CMP: begin
        if (stat.match) begin
          kp <= rd[3*DATA_WIDTH-1:2*DATA_WIDTH];
          ki <= rd[4*DATA_WIDTH-1:3*DATA_WIDTH];
          kd <= rd[5*DATA_WIDTH-1:4*DATA_WIDTH];
          hit <= 1'b1;
          hit_idx <= 4'(scan_idx);
        end else begin
          scan_idx <= scan_idx + CW'(1);
        end
      end
      OP_MUL_I:  p <= sat_q16(prod);
      OP_SAT_I:  t <= sat_q16(prod);
      OP_SAT_DT: t <= sat_q16(prod);
      OP_SAT_B:  t <= sat_q16(prod);
      OP_DIV_INIT: begin
        dsign <= diff[DATA_WIDTH];
        dzero <= (diff == '0);
        q <= {diff_mag, 16'b0};
        rem <= '0;
        div_cnt <= '0;
      end
      OP_DIV_STEP: begin
        rem <= div_ge ? 31'(rem_sh - {1'b0, dt}) : rem_sh[30:0];
        q <= {q[DIV_W-2:0], div_ge};
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      OP_DIV_END: deriv <= deriv_new;
      OP_SAT_D:   d <= sat_q16(prod);
      OP_SUM:     y_r <= ysat[DATA_WIDTH-1:0];
      OP_PUB: begin
        if (cmd_r == CMD_SAMPLE) begin
          res_drive <= y_r;
          res_deriv <= d;
          res_hit <= hit;
          res_idx <= hit_idx;
        end else begin
          res_drive <= last_drive;
          res_deriv <= '0;
          res_hit <= 1'b0;
          res_idx <= '0;
        end
        res_integ <= integ;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/gain_scheduled_pid.sv -----
// Gain-scheduled PID controller, signed Q16.16. Each input word carries a command:
// a sample runs one control step, the other commands load a schedule table entry,
// the default gains or the common gains, and return the last drive. One word is in
// work at a time and every word returns exactly one result word. A sample takes
// longer in schedule mode for each table entry compared and when no entry matches,
// and longer when the integral is boosted. Its time is set by the 49-step
// bit-serial divider for the derivative, the shared 33x33 multiplier used four
// times (five when boosted), and the table search that reads one entry at a time
// from its memory. A new word is taken while the previous result still waits at
// the output. Writing the mode register clears the integral, previous error and
// last drive.
module gain_scheduled_pid
  import gsp_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot, error, nudge, determinant, range_lo, range_hi, gain_p, gain_i, gain_d
  input  logic [263:0] s_axis_tdata,
  // cmd
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // drive, integral_term, derivative_term, entry_index
  output logic [103:0] m_axis_tdata,
  // entry_hit
  output logic         m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_fire;
  logic signed [DATA_WIDTH-1:0] res_drive, res_integ, res_deriv;
  logic     res_hit;
  logic [3:0] res_idx;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  gsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gsp_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_cmd    (s_axis_tuser),
    .in_slot   (s_axis_tdata[3:0]),
    .in_error  (s_axis_tdata[35:4]),
    .in_nudge  (s_axis_tdata[67:36]),
    .in_det    (s_axis_tdata[99:68]),
    .in_lo     (s_axis_tdata[131:100]),
    .in_hi     (s_axis_tdata[163:132]),
    .in_gp     (s_axis_tdata[195:164]),
    .in_gi     (s_axis_tdata[227:196]),
    .in_gd     (s_axis_tdata[259:228]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .res_drive (res_drive),
    .res_integ (res_integ),
    .res_deriv (res_deriv),
    .res_hit   (res_hit),
    .res_idx   (res_idx)
  );

  // result word packing
  assign m_axis_tdata = {4'b0000, res_idx, res_deriv, res_integ, res_drive};
  assign m_axis_tuser = res_hit;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import gsp_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [31:0] drive;
    logic [31:0] integ;
    logic [31:0] deriv;
    logic        hit;
    logic [3:0]  idx;
  } pid_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [263:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = CMD_SAMPLE;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [3:0]   cfg_index = CFG_MODE;
  logic [31:0]  cfg_data = '0;

  gain_scheduled_pid DUT (.*);

  always #2 clk = ~clk;

  // controller state as the block should hold it
  logic        mode_r;
  logic [30:0] dt_r;
  logic [31:0] out_max_r, out_min_r;
  logic [30:0] i_max_r;
  logic [4:0]  entry_cnt_r;
  logic        use_mag_r, ext_sched_r;
  longint      prev_err_q, integ_q, last_drive_q;
  longint      bound_lo[16], bound_hi[16];
  longint      tbl_gain[16][3];
  longint      def_gain[3], com_gain[3];

  pid_result_t pending_results[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles = 0;
  int          errors = 0;
  longint      cycles = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint q16_prod(longint a, longint b);
    return sat32((a * b) >>> 16);
  endfunction

  // one controller step; updates the model state
  function automatic pid_result_t pid_step(logic [1:0] cmd, logic [3:0] slot, longint e,
                                           longint nudge, longint det, longint lo,
                                           longint hi, longint g0, longint g1,
                                           longint g2);
    pid_result_t r;
    longint kp, ki, kd, p, inc, diff, dv, d, y, s, lim;
    int n;
    r.hit = 1'b0;
    r.idx = 4'd0;
    r.deriv = '0;
    if (cmd != CMD_SAMPLE) begin
      case (cmd)
        CMD_WR_ENTRY: begin
          bound_lo[slot] = lo;
          bound_hi[slot] = hi;
          tbl_gain[slot] = '{g0, g1, g2};
        end
        CMD_WR_DEFAULT: def_gain = '{g0, g1, g2};
        default: com_gain = '{g0, g1, g2};
      endcase
      r.drive = last_drive_q[31:0];
      r.integ = integ_q[31:0];
      return r;
    end
    if (!mode_r) begin
      kp = com_gain[0]; ki = com_gain[1]; kd = com_gain[2];
    end else begin
      s = ext_sched_r ? det : e;
      if (use_mag_r && s < 0) s = -s;
      n = entry_cnt_r < 16 ? entry_cnt_r : 16;
      kp = def_gain[0]; ki = def_gain[1]; kd = def_gain[2];
      for (int i = 0; i < n; i++) begin
        if (!r.hit && s >= bound_lo[i] && s < bound_hi[i]) begin
          kp = tbl_gain[i][0]; ki = tbl_gain[i][1]; kd = tbl_gain[i][2];
          r.hit = 1'b1;
          r.idx = i[3:0];
        end
      end
    end
    p = q16_prod(kp, e);
    inc = q16_prod(q16_prod(ki, e), longint'(dt_r));
    // integral winds back faster when it opposes the error
    if ((integ_q > 0 && e < 0) || (e > 0 && integ_q < 0)) inc = q16_prod(inc, 91750);
    integ_q += inc;
    lim = longint'(i_max_r);
    if (integ_q > lim) integ_q = lim;
    else if (integ_q < -lim) integ_q = -lim;
    diff = e - prev_err_q;
    if (dt_r == 0) dv = diff > 0 ? 64'sd2147483647 : (diff < 0 ? -64'sd2147483648 : 0);
    else dv = sat32((diff * 65536) / longint'(dt_r));
    d = q16_prod(kd, dv);
    y = p + integ_q - d + nudge;
    if (y > longint'($signed(out_max_r))) y = $signed(out_max_r);
    else if (y < longint'($signed(out_min_r))) y = $signed(out_min_r);
    prev_err_q = e;
    last_drive_q = y;
    r.drive = y[31:0];
    r.integ = integ_q[31:0];
    r.deriv = d[31:0];
    return r;
  endfunction

  // cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver ready, with random stalls and long hold-off
  always @(negedge clk) begin
    if (rst) m_axis_tready = 1'b0;
    else if (hold_cycles > 0) begin
      m_axis_tready = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // result word checker
  always @(posedge clk) begin
    pid_result_t x;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation: %h", m_axis_tdata);
        errors++;
      end else begin
        x = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== x.drive) begin
          $error("drive exp %h got %h", x.drive, m_axis_tdata[31:0]); errors++;
        end
        if (m_axis_tdata[63:32] !== x.integ) begin
          $error("integral_term exp %h got %h", x.integ, m_axis_tdata[63:32]); errors++;
        end
        if (m_axis_tdata[95:64] !== x.deriv) begin
          $error("derivative_term exp %h got %h", x.deriv, m_axis_tdata[95:64]); errors++;
        end
        if (m_axis_tdata[99:96] !== x.idx) begin
          $error("entry_index exp %h got %h", x.idx, m_axis_tdata[99:96]); errors++;
        end
        if (m_axis_tuser !== x.hit) begin
          $error("entry_hit exp %b got %b", x.hit, m_axis_tuser); errors++;
        end
      end
    end
  end

  // send one word; valid stays high for a following word unless a gap is drawn
  task automatic send_word(logic [1:0] cmd, logic [3:0] slot, logic [31:0] e,
                           logic [31:0] nudge, logic [31:0] det, logic [31:0] lo,
                           logic [31:0] hi, logic [31:0] g0, logic [31:0] g1,
                           logic [31:0] g2);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata = {8'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom};
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = cmd;
    s_axis_tdata = {4'd0, g2, g1, g0, hi, lo, det, nudge, e, slot};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(pid_step(cmd, slot, $signed(e), $signed(nudge), $signed(det),
                                       $signed(lo), $signed(hi), $signed(g0), $signed(g1),
                                       $signed(g2)));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODE: begin
        mode_r = val[0];
        prev_err_q = 0; integ_q = 0; last_drive_q = 0;
      end
      CFG_DT:        dt_r = val[30:0];
      CFG_OUT_MAX:   out_max_r = val;
      CFG_OUT_MIN:   out_min_r = val;
      CFG_I_MAX:     i_max_r = val[30:0];
      CFG_ENTRIES:   entry_cnt_r = val[4:0];
      CFG_USE_MAG:   use_mag_r = val[0];
      CFG_EXT_SCHED: ext_sched_r = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(logic m, logic [30:0] dt, logic [31:0] omax, logic [31:0] omin,
                           logic [30:0] imax, logic [4:0] cnt, logic mag, logic ext);
    wait_idle();
    write_reg(CFG_DT, {1'b0, dt});
    write_reg(CFG_OUT_MAX, omax);
    write_reg(CFG_OUT_MIN, omin);
    write_reg(CFG_I_MAX, {1'b0, imax});
    write_reg(CFG_ENTRIES, {27'd0, cnt});
    write_reg(CFG_USE_MAG, {31'd0, mag});
    write_reg(CFG_EXT_SCHED, {31'd0, ext});
    write_reg(CFG_MODE, {31'd0, m});
  endtask

  // data value biased toward extremes and small magnitudes
  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3, 4: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
      5: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    return $urandom_range(0, 99) < 80 ? $urandom_range(0, 32'h0004_0000) - 32'h0002_0000
                                      : $urandom;
  endfunction

  task automatic write_entry(logic [3:0] slot);
    logic [31:0] lo;
    lo = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    if ($urandom_range(0, 9) == 0) lo = $urandom;
    send_word(CMD_WR_ENTRY, slot, rand_q(), rand_q(), rand_q(), lo,
              lo + $urandom_range(0, 32'h0004_0000), rand_gain(), rand_gain(), rand_gain());
  endtask

  task automatic send_sample(logic [31:0] e, logic [31:0] det);
    send_word(CMD_SAMPLE, 4'($urandom), e, rand_q(), det, $urandom, $urandom, $urandom,
              $urandom, $urandom);
  endtask

  // directed corners: every command, clamps, zero dt, magnitude, entry counts
  task automatic test_directed();
    write_all(1'b0, 31'd65536, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 5'd0, 1'b0,
              1'b0);
    send_word(CMD_WR_COMMON, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(CMD_WR_DEFAULT, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000);
    for (int i = 0; i < 16; i++) write_entry(i[3:0]);
    send_word(CMD_WR_ENTRY, 4'd15, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0002_0000,
              32'h0001_0000, 32'h0001_0000);
    send_sample(32'h7FFF_FFFF, 0);
    send_sample(32'h8000_0000, 0);
    send_sample(32'h8000_0000, 0);
    send_sample(0, 0);
    // zero dt, inverted clamp, zero integral limit
    write_all(1'b0, 31'd0, 32'hFFF0_0000, 32'h0010_0000, 31'd0, 5'd16, 1'b0, 1'b0);
    send_sample(32'h0001_0000, 0);
    send_sample(32'hFFFF_0000, 0);
    send_sample(32'hFFFF_0000, 0);
    // schedule mode, magnitude of the most negative value, external schedule
    write_all(1'b1, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0100_0000, 5'd16, 1'b1,
              1'b0);
    send_sample(32'h8000_0000, 0);
    send_sample(32'hFFFF_8000, 0);
    write_all(1'b1, 31'd1, 32'h0100_0000, 32'hFF00_0000, 31'h7FFF_FFFF, 5'd20, 1'b0, 1'b1);
    send_sample(32'h0000_1000, 32'h8000_0000);
    send_sample(32'hFFFF_0000, 32'h7FFF_FFFF);
    send_sample(32'h0000_0000, 32'h0000_0000);
  endtask

  // random config phases with mostly samples, some table and gain writes
  task automatic test_random(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      write_all(1'($urandom), ($urandom_range(0, 3) == 0) ? 31'($urandom)
                              : 31'($urandom_range(1, 32'h0004_0000)),
                ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFF : rand_q(),
                ($urandom_range(0, 3) == 0) ? 32'h8000_0000 : rand_q(),
                ($urandom_range(0, 3) == 0) ? 31'h7FFF_FFFF : 31'($urandom),
                5'($urandom_range(0, 16)), 1'($urandom), 1'($urandom));
      for (int k = 0; k < 50 && sent < items; k++, sent++) begin
        case ($urandom_range(0, 19))
          0: write_entry(4'($urandom));
          1: send_word(CMD_WR_DEFAULT, 4'($urandom), rand_q(), rand_q(), rand_q(), $urandom,
                       $urandom, rand_gain(), rand_gain(), rand_gain());
          2: send_word(CMD_WR_COMMON, 4'($urandom), rand_q(), rand_q(), rand_q(), $urandom,
                       $urandom, rand_gain(), rand_gain(), rand_gain());
          default: send_sample(rand_q(), rand_q());
        endcase
      end
    end
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    hold_cycles = 600;
    for (int k = 0; k < 8; k++) send_sample(rand_q(), rand_q());
  endtask

  initial begin
    mode_r = 0; dt_r = 31'd65536; out_max_r = 32'h7FFF_FFFF; out_min_r = 32'h8000_0000;
    i_max_r = 31'h7FFF_FFFF; entry_cnt_r = 0; use_mag_r = 0; ext_sched_r = 0;
    prev_err_q = 0; integ_q = 0; last_drive_q = 0;
    def_gain = '{0, 0, 0};
    com_gain = '{0, 0, 0};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    send_idle_pct = 37; recv_idle_pct = 52;
    test_random(350);
    test_backpressure();
    send_idle_pct = 52; recv_idle_pct = 37;
    test_random(350);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(350);
    wait_idle();
    repeat (150) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
